// ===== sv/e2dc_pkg.sv =====
`default_nettype none
package e2dc_pkg;

  localparam int unsigned CordicSteps = 30;

  localparam logic signed [33:0] AngPi     = 34'sd3373259426;
  localparam logic signed [33:0] AngHalfPi = 34'sd1686629713;
  localparam logic signed [34:0] CordicX0  = 35'sd2608131496;
  localparam logic signed [31:0] OneQ30    = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } e2dc_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } e2dc_out_t;

  // Arctangent of 2^-i in Q.30.
  function automatic logic signed [33:0] atan_step(input int unsigned i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      default: begin
        if (i <= 30) r = 34'sd1 <<< (30 - i);
      end
    endcase
    return r;
  endfunction

  // Clamp a wide value to plus or minus one in Q1.30.
  function automatic logic signed [31:0] clamp_one(input logic signed [63:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 64'sd1073741824) r = OneQ30;
    if (v < -64'sd1073741824) r = -OneQ30;
    return r;
  endfunction

  // Round Q.60 to Q.30 and clamp.
  function automatic logic signed [31:0] round60(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v + 64'sd536870912) >>> 30;
    return clamp_one(s);
  endfunction

endpackage
`default_nettype wire

// ===== sv/e2dc_cordic.sv =====
`default_nettype none
// One angle: fold, then one register stage per rotation step, then round.
module e2dc_cordic import e2dc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] ang_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  logic signed [34:0] x_q [CordicSteps+1];
  logic signed [34:0] y_q [CordicSteps+1];
  logic signed [34:0] a_q [CordicSteps+1];
  logic               f_q [CordicSteps+1];

  logic signed [34:0] a_in;
  logic signed [34:0] a_fold;
  logic               f_in;

  always_comb begin
    a_in   = {{2{ang_i[31]}}, ang_i, 1'b0};
    a_fold = a_in;
    f_in   = 1'b0;
    if (a_in > 35'(AngHalfPi)) begin
      a_fold = 35'(AngPi) - a_in;
      f_in   = 1'b1;
    end else if (a_in < -35'(AngHalfPi)) begin
      a_fold = -35'(AngPi) - a_in;
      f_in   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicX0;
      y_q[0] <= '0;
      a_q[0] <= a_fold;
      f_q[0] <= f_in;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (!a_q[i][34]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] - 35'(atan_step(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] + 35'(atan_step(i));
        end
      end
    end
  end

  logic signed [31:0] s_r;
  logic signed [31:0] c_r;

  always_comb begin
    s_r = clamp_one(64'((y_q[CordicSteps] + 35'sd2) >>> 2));
    c_r = clamp_one(64'((x_q[CordicSteps] + 35'sd2) >>> 2));
    if (f_q[CordicSteps]) c_r = -c_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= s_r;
      cos_o <= c_r;
    end
  end

endmodule
`default_nettype wire

// ===== sv/e2dc_matrix.sv =====
`default_nettype none
// Products of the sines and cosines in registered stages A to D.
module e2dc_matrix import e2dc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] s1_i,
  input  wire logic signed [31:0] c1_i,
  input  wire logic signed [31:0] s2_i,
  input  wire logic signed [31:0] c2_i,
  input  wire logic signed [31:0] s3_i,
  input  wire logic signed [31:0] c3_i,
  output e2dc_out_t               res_o
);

  // Stage A: first products.
  logic signed [63:0] p_s1s2_q, p_c1s2_q, p_c2c3_q, p_c2s3_q, p_s1c2_q, p_c1c2_q;
  logic signed [63:0] p_c1s3_q, p_s1s3_q, p_c1c3_q, p_s1c3_q;
  logic signed [31:0] s3_a_q, c3_a_q, s2_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_s1s2_q <= 64'(s1_i) * 64'(s2_i);
      p_c1s2_q <= 64'(c1_i) * 64'(s2_i);
      p_c2c3_q <= 64'(c2_i) * 64'(c3_i);
      p_c2s3_q <= 64'(c2_i) * 64'(s3_i);
      p_s1c2_q <= 64'(s1_i) * 64'(c2_i);
      p_c1c2_q <= 64'(c1_i) * 64'(c2_i);
      p_c1s3_q <= 64'(c1_i) * 64'(s3_i);
      p_s1s3_q <= 64'(s1_i) * 64'(s3_i);
      p_c1c3_q <= 64'(c1_i) * 64'(c3_i);
      p_s1c3_q <= 64'(s1_i) * 64'(c3_i);
      s3_a_q   <= s3_i;
      c3_a_q   <= c3_i;
      s2_a_q   <= s2_i;
    end
  end

  // Stage B: round t and u; round or clamp the single-term elements.
  logic signed [31:0] t_q, u_q, s3_b_q, c3_b_q;
  logic signed [63:0] p_c1s3_b_q, p_s1s3_b_q, p_c1c3_b_q, p_s1c3_b_q;
  logic signed [31:0] m00_b_q, m10_b_q, m20_b_q, m21_b_q, m22_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q        <= round60(p_s1s2_q);
      u_q        <= round60(p_c1s2_q);
      s3_b_q     <= s3_a_q;
      c3_b_q     <= c3_a_q;
      p_c1s3_b_q <= p_c1s3_q;
      p_s1s3_b_q <= p_s1s3_q;
      p_c1c3_b_q <= p_c1c3_q;
      p_s1c3_b_q <= p_s1c3_q;
      m00_b_q    <= round60(p_c2c3_q);
      m10_b_q    <= round60(p_c2s3_q);
      m20_b_q    <= clamp_one(-64'(s2_a_q));
      m21_b_q    <= round60(p_s1c2_q);
      m22_b_q    <= round60(p_c1c2_q);
    end
  end

  // Stage C: second products.
  logic signed [63:0] q_tc3_q, q_uc3_q, q_ts3_q, q_us3_q;
  logic signed [63:0] p_c1s3_c_q, p_s1s3_c_q, p_c1c3_c_q, p_s1c3_c_q;
  logic signed [31:0] m00_c_q, m10_c_q, m20_c_q, m21_c_q, m22_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_tc3_q    <= 64'(t_q) * 64'(c3_b_q);
      q_uc3_q    <= 64'(u_q) * 64'(c3_b_q);
      q_ts3_q    <= 64'(t_q) * 64'(s3_b_q);
      q_us3_q    <= 64'(u_q) * 64'(s3_b_q);
      p_c1s3_c_q <= p_c1s3_b_q;
      p_s1s3_c_q <= p_s1s3_b_q;
      p_c1c3_c_q <= p_c1c3_b_q;
      p_s1c3_c_q <= p_s1c3_b_q;
      m00_c_q    <= m00_b_q;
      m10_c_q    <= m10_b_q;
      m20_c_q    <= m20_b_q;
      m21_c_q    <= m21_b_q;
      m22_c_q    <= m22_b_q;
    end
  end

  // Stage D: sum, round and clamp.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.m00 <= m00_c_q;
      res_o.m01 <= round60(q_tc3_q - p_c1s3_c_q);
      res_o.m02 <= round60(p_s1s3_c_q + q_uc3_q);
      res_o.m10 <= m10_c_q;
      res_o.m11 <= round60(p_c1c3_c_q + q_ts3_q);
      res_o.m12 <= round60(q_us3_q - p_s1c3_c_q);
      res_o.m20 <= m20_c_q;
      res_o.m21 <= m21_c_q;
      res_o.m22 <= m22_c_q;
    end
  end

endmodule
`default_nettype wire

// ===== sv/euler_to_direction_cosine.sv =====
`default_nettype none
// Throughput: one request per cycle; a stall freezes the whole pipeline.
// Reset: asynchronous, active low; clears only the valid bits of the pipeline.
module euler_to_direction_cosine import e2dc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire e2dc_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output e2dc_out_t      out_data_o
);

  // Stages: CORDIC fold register, CordicSteps rotations, sin/cos round,
  // then four matrix stages (products, round, products, sum).
  localparam int unsigned Depth = CordicSteps + 6;

  logic [Depth-1:0] vld_q;
  logic             en;

  // Advance whenever the output is free or holds nothing.
  assign en          = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  logic signed [31:0] s1, c1, s2, c2, s3, c3;

  e2dc_cordic u_roll (
    .clk_i(clk_i), .en_i(en), .ang_i(in_data_i.roll), .sin_o(s1), .cos_o(c1)
  );
  e2dc_cordic u_pitch (
    .clk_i(clk_i), .en_i(en), .ang_i(in_data_i.pitch), .sin_o(s2), .cos_o(c2)
  );
  e2dc_cordic u_yaw (
    .clk_i(clk_i), .en_i(en), .ang_i(in_data_i.yaw), .sin_o(s3), .cos_o(c3)
  );

  e2dc_matrix u_matrix (
    .clk_i(clk_i), .en_i(en),
    .s1_i(s1), .c1_i(c1), .s2_i(s2), .c2_i(c2), .s3_i(s3), .c3_i(c3),
    .res_o(out_data_o)
  );

endmodule
`default_nettype wire
